// ===== hw/rtl/tss_pkg.sv =====
// shared types, constants and the reciprocal table of the taylor sine series core
package tss_pkg;

  localparam int FRAC_BITS  = 13;
  localparam int GUARD_BITS = 8;
  localparam int MAX_ORDER  = 7;
  localparam int REC_BITS   = 30;

  localparam int ANGLE_W = 16;
  localparam int ORDER_W = 3;
  localparam int SINE_W  = 20;

  localparam int TERM_FRAC = FRAC_BITS + GUARD_BITS;
  localparam int MAG_W     = TERM_FRAC + 24;
  localparam int UA_W      = ANGLE_W;
  localparam int X2_W      = 2 * UA_W - 1;
  localparam int CHUNK_W   = 23;
  localparam int OPB_W     = X2_W;
  localparam int PROD_W    = CHUNK_W + OPB_W;
  localparam int ACC_W     = MAG_W + OPB_W + 1;
  localparam int SUM_W     = MAG_W + 5;
  localparam int IDX_W     = 3;
  localparam int X2_SHIFT  = 2 * FRAC_BITS;

  localparam logic [SINE_W-1:0] SINE_MAX = {1'b0, {(SINE_W-1){1'b1}}};

  // round(2^30 / ((2i+2)(2i+3)))
  localparam logic [REC_BITS-1:0] RECIP [MAX_ORDER] = '{
    30'd178956971,
    30'd53687091,
    30'd25565282,
    30'd14913081,
    30'd9761289,
    30'd6882960,
    30'd5113056
  };

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [ORDER_W-1:0]        order;
  } req_t;

  typedef struct packed {
    logic signed [SINE_W-1:0] sine;
    logic                     overflow;
  } res_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic acc_add;
    logic round;
    logic use_recip;
    logic sum_upd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic order_zero;
    logic last_term;
  } status_t;

endpackage

// ===== hw/rtl/taylor_sine_series_core.sv =====
// top level of the taylor sine series core: controller plus datapath
// a request runs n terms, n = order clamped to MAX_ORDER; no new request is taken until it is done
// each term runs two multiplies on one shared 23x31 multiplier (two partial products, add,
//   round) plus a step for the running sum
// reset: synchronous, clears the controller and the result valid; no other state
module taylor_sine_series_core (
  input  logic          clk,
  input  logic          rst,
  // request channel
  input  logic          req_valid,
  output logic          req_stall,
  input  tss_pkg::req_t req,
  // result channel
  output logic          res_valid,
  input  logic          res_stall,
  output tss_pkg::res_t res
);
  import tss_pkg::*;

  // command and status between the sequencer and the datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: one request at a time, result held in the output register
  // so the next request is taken while the result waits
  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: term recurrence, rounding, running sum and output register
  tss_datapath u_datapath (
    .clk    (clk),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .res    (res)
  );

endmodule

// ===== hw/rtl/tss_datapath.sv =====
// datapath of the taylor sine series core: shared multiplier, rounding and running sum
module tss_datapath (
  input  logic             clk,
  input  tss_pkg::cmd_t    cmd,
  input  tss_pkg::req_t    req,
  output tss_pkg::status_t status,
  output tss_pkg::res_t    res
);
  import tss_pkg::*;

  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic [X2_W-1:0]         x2;
  logic signed [SUM_W-1:0] sum;
  logic [IDX_W-1:0]        n;
  logic [IDX_W-1:0]        idx;
  logic                    ovf;
  logic [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]        acc;

  logic [UA_W-1:0]         ua;
  logic [CHUNK_W-1:0]      op_a;
  logic [OPB_W-1:0]        op_b;
  logic [ACC_W-1:0]        rnd_sum;
  logic [ACC_W-1:0]        rnd_sh;
  logic                    rnd_clamp;
  logic signed [SUM_W-1:0] mag_ext;
  logic [SUM_W-1:0]        us;
  logic [SUM_W-1:0]        us_rnd;
  logic                    sat;
  logic [SINE_W-1:0]       r_mag;
  logic [SINE_W-1:0]       sine_next;

  assign ua = req.angle[ANGLE_W-1] ? UA_W'(-req.angle) : UA_W'(req.angle);

  assign status.order_zero = (req.order == '0);
  assign status.last_term  = (IDX_W'(idx + 1'b1) == n);

  // operand select for the shared multiplier
  assign op_a = cmd.mul_hi ? CHUNK_W'(mag[MAG_W-1:CHUNK_W]) : mag[CHUNK_W-1:0];
  assign op_b = cmd.use_recip ? OPB_W'(RECIP[idx]) : x2;

  // round half up on the magnitude, clamp to the term limit
  always_comb begin
    if (cmd.use_recip) begin
      rnd_sum = acc + (ACC_W'(1) << (REC_BITS - 1));
      rnd_sh  = rnd_sum >> REC_BITS;
    end else begin
      rnd_sum = acc + (ACC_W'(1) << (X2_SHIFT - 1));
      rnd_sh  = rnd_sum >> X2_SHIFT;
    end
    rnd_clamp = |rnd_sh[ACC_W-1:MAG_W];
  end

  assign mag_ext = SUM_W'(mag);

  // final rounding to the output format with saturation
  always_comb begin
    us     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    us_rnd = (us + (SUM_W'(1) << (GUARD_BITS - 1))) >> GUARD_BITS;
    if (!sum[SUM_W-1] && us_rnd > SUM_W'(SINE_MAX)) begin
      sat   = 1'b1;
      r_mag = SINE_MAX;
    end else if (sum[SUM_W-1] && us_rnd > SUM_W'(SINE_MAX) + SUM_W'(1)) begin
      sat   = 1'b1;
      r_mag = SINE_MAX + SINE_W'(1);
    end else begin
      sat   = 1'b0;
      r_mag = us_rnd[SINE_W-1:0];
    end
    sine_next = sum[SUM_W-1] ? SINE_W'(-r_mag) : r_mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= req.angle[ANGLE_W-1];
      mag <= MAG_W'({ua, {GUARD_BITS{1'b0}}});
      x2  <= X2_W'(ua) * X2_W'(ua);
      sum <= req.angle[ANGLE_W-1] ? -SUM_W'({ua, {GUARD_BITS{1'b0}}})
                                  : SUM_W'({ua, {GUARD_BITS{1'b0}}});
      n   <= (req.order > IDX_W'(MAX_ORDER)) ? IDX_W'(MAX_ORDER) : req.order;
      idx <= '0;
      ovf <= 1'b0;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod <= op_a * op_b;
    end
    if (cmd.mul_hi) begin
      acc <= ACC_W'(prod);
    end
    if (cmd.acc_add) begin
      acc <= acc + (ACC_W'(prod) << CHUNK_W);
    end
    if (cmd.round) begin
      mag <= rnd_clamp ? {MAG_W{1'b1}} : rnd_sh[MAG_W-1:0];
      ovf <= ovf | rnd_clamp;
    end
    if (cmd.sum_upd) begin
      neg <= ~neg;
      sum <= neg ? sum + mag_ext : sum - mag_ext;
      idx <= idx + 1'b1;
    end
    if (cmd.finish) begin
      res.sine     <= sine_next;
      res.overflow <= ovf | sat;
    end
  end

endmodule

// ===== hw/rtl/tss_ctrl.sv =====
// controller of the taylor sine series core: term sequencing and handshakes
module tss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  output logic             res_valid,
  input  logic             res_stall,
  input  tss_pkg::status_t status,
  output tss_pkg::cmd_t    cmd
);
  import tss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MLO,
    S_MHI,
    S_MACC,
    S_RND,
    S_SUM,
    S_FIN
  } state_t;

  state_t state;
  logic   recip_phase;
  logic   fin_go;

  assign req_stall = (state != S_IDLE);
  assign fin_go    = (state == S_FIN) && (!res_valid || !res_stall);

  always_comb begin
    cmd           = '0;
    cmd.use_recip = recip_phase;
    case (state)
      S_IDLE: cmd.load    = req_valid;
      S_MLO:  cmd.mul_lo  = 1'b1;
      S_MHI:  cmd.mul_hi  = 1'b1;
      S_MACC: cmd.acc_add = 1'b1;
      S_RND:  cmd.round   = 1'b1;
      S_SUM:  cmd.sum_upd = 1'b1;
      S_FIN:  cmd.finish  = fin_go;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      recip_phase <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (fin_go) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          recip_phase <= 1'b0;
          if (req_valid) begin
            state <= status.order_zero ? S_FIN : S_MLO;
          end
        end
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_MACC;
        S_MACC: state <= S_RND;
        S_RND: begin
          if (!recip_phase) begin
            recip_phase <= 1'b1;
            state       <= S_MLO;
          end else begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          recip_phase <= 1'b0;
          state       <= status.last_term ? S_FIN : S_MLO;
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tss_sine_checker.sv =====
// request/result checker for the taylor sine series core: fixed point sine prediction and compare
module tss_sine_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  tss_pkg::req_t req,
  input  logic          res_valid,
  input  logic          res_stall,
  input  tss_pkg::res_t res,
  output int            mismatches,
  output int            outstanding
);

  localparam int GUARD     = 8;
  localparam int RECIP_FRAC = 30;
  localparam int TERM_BITS = tss_pkg::FRAC_BITS + GUARD + 24;
  localparam logic [127:0] TERM_CAP = (128'd1 << TERM_BITS) - 128'd1;
  localparam logic [63:0] SINE_POS_MAX = 64'd524287;

  tss_pkg::res_t sine_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // reciprocal of (2i+2)(2i+3) with 30 fraction bits, rounded
  function automatic logic [63:0] term_recip(input int i);
    logic [63:0] d;
    d = 64'((2 * i + 2) * (2 * i + 3));
    return ((64'd1 << RECIP_FRAC) + d / 64'd2) / d;
  endfunction

  // magnitude times factor, shifted right with half-up rounding, capped at the term limit
  function automatic logic [63:0] scale_term(input logic [63:0] m, input logic [63:0] f,
                                             input int sh, inout bit capped);
    logic [127:0] p;
    p = 128'(m) * 128'(f);
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > TERM_CAP) begin
      capped = 1'b1;
      return TERM_CAP[63:0];
    end
    return p[63:0];
  endfunction

  function automatic tss_pkg::res_t predict_sine(input tss_pkg::req_t r);
    tss_pkg::res_t o;
    logic [63:0]   ua;
    logic [63:0]   x2;
    logic [63:0]   mag;
    logic [63:0]   us;
    logic [63:0]   rnd;
    logic [63:0]   val;
    longint        sum;
    bit            neg;
    bit            sneg;
    bit            capped;
    int            n;
    neg    = r.angle[tss_pkg::ANGLE_W-1];
    ua     = neg ? (64'h10000 - 64'($unsigned(r.angle))) : 64'($unsigned(r.angle));
    x2     = ua * ua;
    n      = int'(r.order);
    capped = 1'b0;
    if (n > tss_pkg::MAX_ORDER) n = tss_pkg::MAX_ORDER;
    mag = ua << GUARD;
    sum = neg ? -longint'(mag) : longint'(mag);
    for (int i = 0; i < n; i++) begin
      mag = scale_term(mag, x2, 2 * tss_pkg::FRAC_BITS, capped);
      mag = scale_term(mag, term_recip(i), RECIP_FRAC, capped);
      neg = !neg;
      if (neg) sum = sum - longint'(mag);
      else sum = sum + longint'(mag);
    end
    sneg = sum < 0;
    us   = sneg ? (64'd0 - 64'(sum)) : 64'(sum);
    rnd  = (us + (64'd1 << (GUARD - 1))) >> GUARD;
    if (!sneg && rnd > SINE_POS_MAX) begin
      rnd    = SINE_POS_MAX;
      capped = 1'b1;
    end else if (sneg && rnd > SINE_POS_MAX + 64'd1) begin
      rnd    = SINE_POS_MAX + 64'd1;
      capped = 1'b1;
    end
    val        = sneg ? (64'd0 - rnd) : rnd;
    o.sine     = val[tss_pkg::SINE_W-1:0];
    o.overflow = capped;
    return o;
  endfunction

  always @(posedge clk) begin
    tss_pkg::res_t want;
    if (!rst) begin
      // results first: a request accepted now cannot finish in the same cycle
      if (res_valid && !res_stall) begin
        if (sine_q.size() == 0) begin
          $display("%0t: unexpected result sine %0d overflow %0d", $time, res.sine,
                   res.overflow);
          mismatches = mismatches + 1;
        end else begin
          want = sine_q.pop_front();
          if (res.sine !== want.sine) begin
            $display("%0t: sine mismatch expected %0d actual %0d", $time, want.sine,
                     res.sine);
            mismatches = mismatches + 1;
          end
          if (res.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch expected %0d actual %0d", $time,
                     want.overflow, res.overflow);
            mismatches = mismatches + 1;
          end
        end
      end
      if (req_valid && !req_stall) sine_q.push_back(predict_sine(req));
      outstanding = sine_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the taylor sine series core: stimulus, handshake idling, watchdog and verdict
module tb_top;

  // random request count and watchdog limit; the limit leaves ample margin over the idle,
  // busy and stalled time of the slowest request
  localparam int RAND_REQUESTS  = 530;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int N_DIRECTED     = 20;

  // directed requests: field extremes, +-1.0, +-pi/2, +-pi, every order 0..7
  localparam logic signed [15:0] DIR_ANGLE [N_DIRECTED] = '{
    16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
    16'sd8192, -16'sd8192, 16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736,
    16'sd16384, -16'sd16384, 16'sd32767, -16'sd32768, 16'sd0, 16'sd21845, -16'sd10923
  };
  localparam logic [2:0] DIR_ORDER [N_DIRECTED] = '{
    3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd7, 3'd7, 3'd1, 3'd2, 3'd3,
    3'd4, 3'd5, 3'd6, 3'd7, 3'd7, 3'd1, 3'd1, 3'd7, 3'd3, 3'd5
  };

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  tss_pkg::req_t req       = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  tss_pkg::res_t res;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;

  // runs of back-to-back traffic on each side, toggled at random
  bit req_eager = 1'b0;
  bit res_eager = 1'b0;

  always #5 clk = ~clk;

  taylor_sine_series_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  tss_sine_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // idle cycles before the next request or result, none while in an eager run
  function automatic int idle_draw(inout bit eager);
    if ($urandom_range(0, 15) == 0) eager = !eager;
    return eager ? 0 : int'($urandom_range(0, 17));
  endfunction

  // one request: optional gap with valid low, then hold the payload until accepted
  task automatic send_request(input logic signed [15:0] angle, input logic [2:0] order);
    int gap;
    gap = idle_draw(req_eager);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req.angle   <= angle;
    req.order   <= order;
    @(posedge clk);
    // signals read here still hold the values sampled at this edge
    while (!(req_valid && !req_stall)) @(posedge clk);
  endtask

  // random angle: mostly full range, some near zero, some at the extremes
  function automatic logic signed [15:0] rand_angle();
    logic signed [15:0] a;
    case ($urandom_range(0, 5))
      0: a = 16'($signed($urandom_range(0, 16383)) - 8192);
      1: begin
        case ($urandom_range(0, 5))
          0: a = 16'sd32767;
          1: a = -16'sd32768;
          2: a = -16'sd32767;
          3: a = 16'sd1;
          4: a = -16'sd1;
          default: a = 16'sd0;
        endcase
      end
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  // result side: stall for a random number of cycles, then take one result
  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      hold = idle_draw(res_eager);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!(res_valid && !res_stall)) @(posedge clk);
    end
  end

  // watchdog: too long without any handshake on either channel means a hang
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : request_source
    // synchronous reset held from time zero, then released
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(DIR_ANGLE[i], DIR_ORDER[i]);
    end

    // random part, all orders equally likely
    for (int i = 0; i < RAND_REQUESTS; i++) begin
      send_request(rand_angle(), 3'($urandom_range(0, 7)));
    end
    req_valid <= 1'b0;

    // let the checker queue the last request
    @(posedge clk);

    // wait for every predicted sine, then a little longer for strays
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
